### src/siph_pkg.sv
// Shared types, constants and the SipHash round function for the SipHash-1-3 stream block.
// No dependencies; every other file depends on this package.
`default_nettype none

package siph_pkg;

	localparam int unsigned WordW  = 64;
	localparam int unsigned CountW = 4;
	localparam int unsigned LenW   = 8;
	localparam int unsigned CfgIdxW = 1;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] CfgKeyLow  = 1'b0;
	localparam logic [CfgIdxW-1:0] CfgKeyHigh = 1'b1;

	// initialization constants
	localparam logic [WordW-1:0] SipC0 = 64'h736f6d6570736575;
	localparam logic [WordW-1:0] SipC1 = 64'h646f72616e646f6d;
	localparam logic [WordW-1:0] SipC2 = 64'h6c7967656e657261;
	localparam logic [WordW-1:0] SipC3 = 64'h7465646279746573;

	// finalization flip on lane two
	localparam logic [WordW-1:0] FinalFlip = 64'h00000000000000ff;
	// bit position of the length byte in the last word
	localparam int unsigned LenShift = 56;

	typedef logic [WordW-1:0] word_t;
	typedef logic [CountW-1:0] count_t;
	typedef logic [LenW-1:0] len_t;

	typedef struct packed {
		word_t v0;
		word_t v1;
		word_t v2;
		word_t v3;
	} lanes_t;

	// controls for the shared round step
	typedef struct packed {
		logic absorb;
		logic flip;
	} step_ctl_t;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		rotl = (x << n) | (x >> (WordW - n));
	endfunction

	// one ARX round over the four lanes
	function automatic lanes_t sip_round(input lanes_t a);
		lanes_t r;
		r = a;
		r.v0 = r.v0 + r.v1;
		r.v1 = rotl(r.v1, 13) ^ r.v0;
		r.v0 = rotl(r.v0, 32);
		r.v2 = r.v2 + r.v3;
		r.v3 = rotl(r.v3, 16) ^ r.v2;
		r.v0 = r.v0 + r.v3;
		r.v3 = rotl(r.v3, 21) ^ r.v0;
		r.v2 = r.v2 + r.v1;
		r.v1 = rotl(r.v1, 17) ^ r.v2;
		r.v2 = rotl(r.v2, 32);
		sip_round = r;
	endfunction

endpackage

`default_nettype wire

### src/siph_if.sv
// Valid/ready channel interfaces for message words and digests.
// Depends on siph_pkg for the payload types.
`default_nettype none

interface siph_msg_if;
	logic                valid;
	logic                ready;
	siph_pkg::word_t     message_word;
	siph_pkg::count_t    byte_count;
	logic                final_item;

	modport source(output valid, output message_word, output byte_count,
		output final_item, input ready);
	modport sink(input valid, input message_word, input byte_count,
		input final_item, output ready);
endinterface

interface siph_hash_if;
	logic                valid;
	logic                ready;
	siph_pkg::word_t     digest;

	modport source(output valid, output digest, input ready);
	modport sink(input valid, input digest, output ready);
endinterface

`default_nettype wire

### src/siph_step.sv
// Combinational SipHash step: optional message absorb around one round,
// optional finalization flip on lane two. Depends on siph_pkg.
`default_nettype none

module siph_step (
	input  wire siph_pkg::lanes_t    lanes_in,
	input  wire siph_pkg::word_t     msg,
	input  wire siph_pkg::step_ctl_t ctl,
	output siph_pkg::lanes_t         lanes_out
);
	import siph_pkg::*;

	lanes_t pre;
	lanes_t post;
	word_t  m_eff;

	// gate the message word, flip lane two before the round when finalizing
	assign m_eff = ctl.absorb ? msg : '0;

	always_comb begin
		pre = lanes_in;
		pre.v3 = lanes_in.v3 ^ m_eff;
		pre.v2 = lanes_in.v2 ^ (ctl.flip ? FinalFlip : '0);
	end

	assign post = sip_round(pre);

	// fold the message into lane zero after the round
	always_comb begin
		lanes_out = post;
		lanes_out.v0 = post.v0 ^ m_eff;
	end

endmodule

`default_nettype wire

### src/siphash_1_3_stream.sv
// Top level of the streaming keyed SipHash-1-3 hasher: key registers, lane state,
// finalization sequencer and digest output register. Depends on siph_pkg, siph_if, siph_step.
//
//  channel   dir   handshake      payload
//  msg       in    valid/ready    message_word[63:0], byte_count[3:0], final_item
//  hash      out   valid/ready    digest[63:0]
//  wr_*      in    wr_en only     wr_index[0], wr_data[63:0]
//
// A full word that does not end the message takes one round in the lane logic.
// A word that ends the message holds msg.ready low through ST_R1 to ST_R3 (and ST_LEN if it
// carries 8 bytes, for the length-only word), one round per cycle through the single
// round step. The digest sits in an output register; further full words are taken while
// it waits, and the last finalization round holds until that register is free.
// arst_n clears keys, lanes, length and the sequencer; the digest register needs no reset.
`default_nettype none

module siphash_1_3_stream (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          wr_en,
	input  wire [siph_pkg::CfgIdxW-1:0]  wr_index,
	input  wire siph_pkg::word_t         wr_data,
	siph_msg_if.sink                     msg,
	siph_hash_if.source                  hash
);
	import siph_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LEN  = 5'b00010,
		ST_R1   = 5'b00100,
		ST_R2   = 5'b01000,
		ST_R3   = 5'b10000
	} state_t;

	state_t    state_q;
	word_t     key_low_q;
	word_t     key_high_q;
	lanes_t    lanes_q;
	len_t      len_q;
	logic      start_q;
	logic      out_valid_q;
	word_t     digest_q;

	logic      accept;
	logic      full_word;
	count_t    count_c;
	len_t      len_next;
	word_t     tail_mask;
	word_t     tail_word;
	lanes_t    seed;
	lanes_t    step_in;
	lanes_t    step_out;
	word_t     step_msg;
	step_ctl_t step_ctl;
	logic      out_free;
	logic      emit;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CfgKeyLow:  key_low_q  <= wr_data;
				CfgKeyHigh: key_high_q <= wr_data;
				default: ;
			endcase
		end
	end

	// decode the beat: clamp oversized counts, mask stray bytes, count length
	assign accept    = msg.valid && msg.ready;
	assign full_word = msg.byte_count[CountW-1];
	assign count_c   = full_word ? count_t'(8) : msg.byte_count;
	assign len_next  = (start_q ? len_t'(0) : len_q) + len_t'(count_c);
	assign tail_mask = ~({WordW{1'b1}} << {msg.byte_count[2:0], 3'b000});
	assign tail_word = (msg.message_word & tail_mask) | (word_t'(len_next) << LenShift);

	assign seed.v0 = SipC0 ^ key_low_q;
	assign seed.v1 = SipC1 ^ key_high_q;
	assign seed.v2 = SipC2 ^ key_low_q;
	assign seed.v3 = SipC3 ^ key_high_q;

	// select what the shared round step works on this cycle
	always_comb begin
		step_in  = lanes_q;
		step_msg = word_t'(len_q) << LenShift;
		step_ctl = '{absorb: 1'b0, flip: 1'b0};
		case (state_q)
			ST_IDLE: begin
				step_in  = start_q ? seed : lanes_q;
				step_msg = full_word ? msg.message_word : tail_word;
				step_ctl = '{absorb: 1'b1, flip: 1'b0};
			end
			ST_LEN: step_ctl = '{absorb: 1'b1, flip: 1'b0};
			ST_R1:  step_ctl = '{absorb: 1'b0, flip: 1'b1};
			ST_R2:  step_ctl = '{absorb: 1'b0, flip: 1'b0};
			ST_R3:  step_ctl = '{absorb: 1'b0, flip: 1'b0};
			default: step_ctl = '{absorb: 1'b0, flip: 1'b0};
		endcase
	end

	siph_step u_step (
		.lanes_in (step_in),
		.msg      (step_msg),
		.ctl      (step_ctl),
		.lanes_out(step_out)
	);

	assign out_free = !out_valid_q || hash.ready;
	assign emit     = (state_q == ST_R3) && out_free;
	assign msg.ready = (state_q == ST_IDLE);

	// lane state, length and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lanes_q <= '0;
			len_q   <= '0;
			start_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lanes_q <= step_out;
						len_q   <= len_next;
						start_q <= 1'b0;
						if (!full_word) begin
							state_q <= ST_R1;
							start_q <= 1'b1;
						end else if (msg.final_item) begin
							state_q <= ST_LEN;
							start_q <= 1'b1;
						end
					end
				end
				ST_LEN: begin
					lanes_q <= step_out;
					state_q <= ST_R1;
				end
				ST_R1: begin
					lanes_q <= step_out;
					state_q <= ST_R2;
				end
				ST_R2: begin
					lanes_q <= step_out;
					state_q <= ST_R3;
				end
				ST_R3: begin
					// hold the last round until the digest register is free
					if (out_free) begin
						lanes_q <= step_out;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (hash.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			digest_q <= step_out.v0 ^ step_out.v1 ^ step_out.v2 ^ step_out.v3;
		end
	end

	assign hash.valid  = out_valid_q;
	assign hash.digest = digest_q;

	// a finished last round always lands a beat in the output register
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> hash.valid)
		else $error("digest not presented after last round");

	// an ending beat starts finalization
	a_final_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (!full_word || msg.final_item)) |=>
			(state_q == ST_LEN || state_q == ST_R1))
		else $error("finalization not started");

	// while finalizing, the next beat reseeds the lanes
	a_start_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> start_q)
		else $error("message start flag lost during finalization");

	// the first finalization round advances straight to the second
	a_round_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_R1) |=> (state_q == ST_R2))
		else $error("finalization round skipped or held");

	// the digest register is only overwritten when free
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(hash.valid && !hash.ready && state_q == ST_R3) |=> (state_q == ST_R3))
		else $error("last round advanced over a waiting digest");

endmodule

`default_nettype wire

### bench/siphash_1_3_stream_test.sv
// Self-checking bench for the streaming SipHash-1-3 hasher: a directed table, then random messages.
// Digests are predicted in-bench and compared beat by beat; uses siph_pkg and the siph_if channels.
`timescale 1ns / 100ps

module siphash_1_3_stream_test;
	import siph_pkg::*;

	localparam int unsigned RandBeats   = 850;
	localparam int unsigned DrainCycles = 10;
	localparam int unsigned WatchLimit  = 1500;
	localparam int unsigned DirRows     = 24;

	typedef enum logic [1:0] {RowBeat, RowKeyLow, RowKeyHigh} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		word_t     data;
		count_t    cnt;
		logic      fin;
	} stim_row_t;

	typedef struct packed {
		word_t l0;
		word_t l1;
		word_t l2;
		word_t l3;
	} lane_set_t;

	typedef enum logic [1:0] {RxFree, RxPatchy, RxStingy} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CfgIdxW-1:0] wr_index;
	word_t wr_data;

	siph_msg_if  msg_ch ();
	siph_hash_if hash_ch ();

	siphash_1_3_stream dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.msg      (msg_ch),
		.hash     (hash_ch)
	);

	// hash state mirror
	word_t       shadow_key_lo = '0;
	word_t       shadow_key_hi = '0;
	lane_set_t   lanes = '0;
	len_t        msg_len = '0;
	logic        fresh = 1'b1;
	word_t       digest_q[$];

	int unsigned errors = 0;
	int unsigned burst_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned rx_left = 0;
	rx_mode_t    rx_mode = RxFree;

	stim_row_t   dir_tab [0:DirRows-1];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report(input string what);
		$display("mismatch @%0t: %s", $time, what);
		errors++;
	endtask

	// one ARX round, rotations spelled as slices
	function automatic lane_set_t arx_round(input lane_set_t s);
		word_t a, b, c, d;
		a = s.l0;
		b = s.l1;
		c = s.l2;
		d = s.l3;
		a = a + b;
		b = {b[50:0], b[63:51]} ^ a;
		a = {a[31:0], a[63:32]};
		c = c + d;
		d = {d[47:0], d[63:48]} ^ c;
		a = a + d;
		d = {d[42:0], d[63:43]} ^ a;
		c = c + b;
		b = {b[46:0], b[63:47]} ^ c;
		c = {c[31:0], c[63:32]};
		return '{a, b, c, d};
	endfunction

	function automatic lane_set_t take_word(input lane_set_t s, input word_t m);
		lane_set_t r;
		r = s;
		r.l3 = r.l3 ^ m;
		r = arx_round(r);
		r.l0 = r.l0 ^ m;
		return r;
	endfunction

	// advance the mirror by one accepted beat; queue a digest when the message closes
	task automatic hash_beat(input word_t w, input count_t c_in, input logic f);
		count_t c;
		word_t  tail;
		c = (c_in > 4'd8) ? 4'd8 : c_in;
		if (fresh) begin
			lanes.l0 = SipC0 ^ shadow_key_lo;
			lanes.l1 = SipC1 ^ shadow_key_hi;
			lanes.l2 = SipC2 ^ shadow_key_lo;
			lanes.l3 = SipC3 ^ shadow_key_hi;
			msg_len = '0;
			fresh = 1'b0;
		end
		msg_len = msg_len + len_t'(c);
		if (c == 4'd8) begin
			lanes = take_word(lanes, w);
			if (!f)
				return;
			tail = '0;
		end else begin
			tail = w & ((64'd1 << (8 * c)) - 64'd1);
		end
		lanes = take_word(lanes, (word_t'(msg_len) << LenShift) | tail);
		lanes.l2 = lanes.l2 ^ FinalFlip;
		repeat (3) lanes = arx_round(lanes);
		digest_q.push_back(lanes.l0 ^ lanes.l1 ^ lanes.l2 ^ lanes.l3);
		fresh = 1'b1;
	endtask

	// drive one beat in bursts with random gaps, then wait for the handshake
	task automatic send_word(input word_t w, input count_t c, input logic f);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				msg_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		msg_ch.valid        <= 1'b1;
		msg_ch.message_word <= w;
		msg_ch.byte_count   <= c;
		msg_ch.final_item   <= f;
		@(posedge clk);
		while (!msg_ch.ready) @(posedge clk);
		hash_beat(w, c, f);
	endtask

	// drop valid, let every digest come back, then let the block settle
	task automatic wait_idle();
		msg_ch.valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input word_t val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == CfgKeyLow)
			shadow_key_lo = val;
		else
			shadow_key_hi = val;
		@(posedge clk);
	endtask

	function automatic word_t pick_key();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic rekey();
		int unsigned which;
		which = $urandom_range(0, 2);
		wait_idle();
		if (which != 1)
			write_reg(CfgKeyLow, pick_key());
		if (which != 0)
			write_reg(CfgKeyHigh, pick_key());
	endtask

	// check digests in order; stall the output on a changing pattern
	always @(posedge clk) begin
		if (arst_n && hash_ch.valid && hash_ch.ready) begin
			if (digest_q.size() == 0)
				report($sformatf("digest %h with none expected", hash_ch.digest));
			else if (hash_ch.digest !== digest_q[0])
				report($sformatf("digest %h, expected %h", hash_ch.digest, digest_q.pop_front()));
			else
				void'(digest_q.pop_front());
		end
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(20, 120);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RxFree:   hash_ch.ready <= 1'b1;
			RxPatchy: hash_ch.ready <= ($urandom_range(0, 3) != 0);
			default:  hash_ch.ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((msg_ch.valid && msg_ch.ready) || (hash_ch.valid && hash_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WatchLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned beats_sent;
		int unsigned n_words;
		int unsigned key_at;
		int unsigned pick;
		count_t      c;
		logic        f;

		arst_n              = 1'b0;
		wr_en               = 1'b0;
		wr_index            = CfgKeyLow;
		wr_data             = '0;
		msg_ch.valid        = 1'b0;
		msg_ch.message_word = '0;
		msg_ch.byte_count   = '0;
		msg_ch.final_item   = 1'b0;
		hash_ch.ready       = 1'b0;

		// every row is checked against the mirror; key rows wait for the block to go idle
		dir_tab = '{
			'{RowBeat,    64'h0000_0000_0000_0000, 4'd0,  1'b1},  // empty message, reset key
			'{RowBeat,    64'hffff_ffff_ffff_ffff, 4'd8,  1'b1},  // full last word, length word follows
			'{RowBeat,    64'hff00_0000_0000_0001, 4'd7,  1'b1},  // stray top byte ignored
			'{RowKeyLow,  64'hffff_ffff_ffff_ffff, 4'd0,  1'b0},
			'{RowKeyHigh, 64'hffff_ffff_ffff_ffff, 4'd0,  1'b0},
			'{RowBeat,    64'h0000_0000_0000_0000, 4'd8,  1'b0},
			'{RowBeat,    64'hffff_ffff_ffff_ffff, 4'd8,  1'b0},
			'{RowBeat,    64'hffff_ffff_ffff_ffff, 4'd7,  1'b0},  // short word closes the message
			'{RowBeat,    64'h0123_4567_89ab_cdef, 4'd15, 1'b1},  // oversized count, last
			'{RowBeat,    64'hfedc_ba98_7654_3210, 4'd9,  1'b0},  // oversized count keeps going
			'{RowBeat,    64'haaaa_aaaa_aa12_3456, 4'd3,  1'b1},
			'{RowKeyLow,  64'h0706_0504_0302_0100, 4'd0,  1'b0},
			'{RowKeyHigh, 64'h0f0e_0d0c_0b0a_0908, 4'd0,  1'b0},
			'{RowBeat,    64'h0706_0504_0302_0100, 4'd8,  1'b0},
			'{RowBeat,    64'h0f0e_0d0c_0b0a_0908, 4'd8,  1'b0},
			'{RowKeyLow,  64'h0000_0000_0000_0000, 4'd0,  1'b0},  // key change mid-message
			'{RowKeyHigh, 64'h8000_0000_0000_0000, 4'd0,  1'b0},
			'{RowBeat,    64'h5a5a_5a5a_5a5a_5a10, 4'd1,  1'b1},  // still hashed under the old key
			'{RowBeat,    64'hffff_ffff_ffff_ffff, 4'd4,  1'b1},  // new key takes effect
			'{RowBeat,    64'h8000_0000_0000_0001, 4'd8,  1'b1},
			'{RowBeat,    64'h0000_0000_0000_0000, 4'd2,  1'b0},
			'{RowBeat,    64'haaaa_aaaa_aaaa_aaaa, 4'd8,  1'b0},
			'{RowBeat,    64'h5555_5555_5555_5555, 4'd6,  1'b1},
			'{RowBeat,    64'h0000_0000_0000_0000, 4'd0,  1'b0}   // empty short word, a message of its own
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		for (int r = 0; r < DirRows; r++) begin
			case (dir_tab[r].kind)
				RowKeyLow: begin
					wait_idle();
					write_reg(CfgKeyLow, dir_tab[r].data);
				end
				RowKeyHigh: begin
					wait_idle();
					write_reg(CfgKeyHigh, dir_tab[r].data);
				end
				default: send_word(dir_tab[r].data, dir_tab[r].cnt, dir_tab[r].fin);
			endcase
		end

		// random messages: mostly short, now and then long enough to wrap the length byte
		beats_sent = 0;
		while (beats_sent < RandBeats) begin
			if ($urandom_range(0, 9) == 0)
				rekey();
			n_words = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 5);
			key_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n_words) : n_words + 1;
			for (int w = 0; w < n_words; w++) begin
				if (w == key_at)
					rekey();
				c = ($urandom_range(0, 7) == 0) ? count_t'($urandom_range(9, 15)) : count_t'(8);
				send_word({$urandom, $urandom}, c, 1'b0);
				beats_sent++;
			end
			if (key_at == n_words)
				rekey();
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				c = count_t'($urandom_range(0, 8));
				f = 1'b1;
			end else if (pick == 6) begin
				c = count_t'($urandom_range(0, 7));
				f = 1'b0;
			end else if (pick == 7) begin
				c = count_t'($urandom_range(9, 15));
				f = 1'($urandom_range(0, 1));
			end else if (pick == 8) begin
				c = count_t'(8);
				f = 1'b1;
			end else begin
				c = count_t'($urandom_range(0, 7));
				f = 1'($urandom_range(0, 1));
			end
			send_word({$urandom, $urandom}, c, f);
			beats_sent++;
		end

		wait_idle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
